/* rtl/core/mccl_pkg.sv */
// ----------------------------------------------------------------------------
// mccl_pkg
// Shared types and constants of the MIDI CC learn and auto-range mapper.
// ----------------------------------------------------------------------------
package mccl_pkg;

  localparam int SLOTS       = 8;
  localparam int SLOT_W      = 3;
  localparam int VAL_W       = 7;
  localparam int FRAC_W      = 16;
  localparam int SCALED_W    = 24;
  localparam int MAX_RESULTS = 8;
  localparam int NEMIT_W     = $clog2(MAX_RESULTS + 1);

  // restoring divider: one quotient bit per cycle over |raw-low| << 16
  localparam int DIV_W       = VAL_W + FRAC_W;
  localparam int DIV_STEPS   = DIV_W;
  localparam int CNT_W       = $clog2(DIV_STEPS + 1);

  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);

  localparam logic [2:0]       FUNC_MIDI      = 3'd0;
  localparam logic [2:0]       FUNC_ARM       = 3'd1;
  localparam logic [2:0]       FUNC_SET_CTRL  = 3'd2;
  localparam logic [2:0]       FUNC_SET_LOW   = 3'd3;
  localparam logic [2:0]       FUNC_SET_HIGH  = 3'd4;
  localparam logic [3:0]       CC_STATUS_HI   = 4'hB;
  localparam logic [VAL_W-1:0] VAL_TOP        = 7'd127;

  localparam logic signed [SCALED_W:0] SAT_HI = 25'sd8388607;
  localparam logic signed [SCALED_W:0] SAT_LO = -25'sd8388608;

  typedef enum logic [2:0] {
    OP_CC,
    OP_ARM,
    OP_SET_CTRL,
    OP_SET_LOW,
    OP_SET_HIGH
  } op_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [7:0]        status_byte;
    logic [VAL_W-1:0]  controller_byte;
    logic [VAL_W-1:0]  value_byte;
    logic [SLOT_W-1:0] slot_index;
    logic [VAL_W-1:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]          out_slot;
    logic [VAL_W-1:0]           out_controller;
    logic [VAL_W-1:0]           out_low;
    logic [VAL_W-1:0]           out_high;
    logic [VAL_W-1:0]           out_raw;
    logic signed [SCALED_W-1:0] scaled_value;
    logic                       last_result;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  ctrl;
    logic [VAL_W-1:0]  data;
  } cmd_t;

  typedef struct packed {
    logic         full;
    logic         empty;
    logic [QAW:0] count;
  } q_stat_t;

endpackage

/* rtl/core/mccl_front.sv */
// ----------------------------------------------------------------------------
// mccl_front
// Accepts input items, drops the ones that do nothing and turns the rest into
// commands for the command queue.
// ----------------------------------------------------------------------------
module mccl_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  mccl_pkg::in_item_t in_data,
  input  mccl_pkg::q_stat_t  q_stat,
  output logic               q_push,
  output mccl_pkg::cmd_t     q_cmd
);
  import mccl_pkg::*;

  logic accept;
  logic slot_ok;
  logic keep;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign slot_ok  = ({1'b0, in_data.slot_index} < (SLOT_W + 1)'(SLOTS));

  always_comb begin
    q_cmd.op   = OP_CC;
    q_cmd.slot = in_data.slot_index;
    q_cmd.ctrl = in_data.controller_byte;
    q_cmd.data = in_data.write_data;
    keep       = 1'b0;
    case (in_data.func)
      FUNC_MIDI: begin
        q_cmd.data = in_data.value_byte;
        keep       = (in_data.status_byte[7:4] == CC_STATUS_HI);
      end
      FUNC_ARM: begin
        q_cmd.op = OP_ARM;
        keep     = slot_ok;
      end
      FUNC_SET_CTRL: begin
        q_cmd.op = OP_SET_CTRL;
        keep     = slot_ok;
      end
      FUNC_SET_LOW: begin
        q_cmd.op = OP_SET_LOW;
        keep     = slot_ok;
      end
      FUNC_SET_HIGH: begin
        q_cmd.op = OP_SET_HIGH;
        keep     = slot_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // dropped items are still a transfer, they just never reach the queue
  assign q_push = accept && keep;

endmodule

/* rtl/core/mccl_cmd_queue.sv */
// ----------------------------------------------------------------------------
// mccl_cmd_queue
// Small command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module mccl_cmd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mccl_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output mccl_pkg::cmd_t     head,
  output mccl_pkg::q_stat_t  stat
);
  import mccl_pkg::*;

  cmd_t         mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;
  logic           do_push;
  logic           do_pop;

  assign stat.full  = (count_r == (QAW + 1)'(QDEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (QAW + 1)'(1);
        2'b01:   count_r <= count_r - (QAW + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/core/mccl_back.sv */
// ----------------------------------------------------------------------------
// mccl_back
// Executes queued commands: slot state, learn, range update, and a serial
// divider for the normalized value; holds one result in an output register.
// ----------------------------------------------------------------------------
module mccl_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mccl_pkg::q_stat_t   q_stat,
  input  mccl_pkg::cmd_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output mccl_pkg::out_item_t out_data
);
  import mccl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_PICK,
    S_UPD,
    S_LOAD,
    S_DIV,
    S_OUT
  } state_t;

  state_t             state_r;
  cmd_t               cmd_r;
  logic [SLOT_W-1:0]  cur_r;
  logic [SLOTS-1:0]   armed_r;
  logic               pending_r;
  logic [VAL_W-1:0]   ctrl_r [SLOTS];
  logic [VAL_W-1:0]   low_r  [SLOTS];
  logic [VAL_W-1:0]   high_r [SLOTS];
  logic [VAL_W-1:0]   raw_r  [SLOTS];
  logic [SLOTS-1:0]   mask_r;
  logic [NEMIT_W-1:0] n_emit_r;
  logic               last_r;

  logic [DIV_W-1:0]   dq_r;
  logic [VAL_W-1:0]   rem_r;
  logic [VAL_W-1:0]   smag_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               sign_r;
  logic               zero_r;
  logic signed [VAL_W:0] diff_r;

  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [VAL_W-1:0]   cur_low;
  logic [VAL_W-1:0]   cur_high;
  logic [VAL_W-1:0]   cur_raw;
  logic signed [VAL_W:0] diff;
  logic signed [VAL_W:0] span;
  logic [VAL_W:0]     diff_mag;
  logic [VAL_W:0]     span_mag;
  logic [VAL_W:0]     trial;
  logic               ge;
  logic [VAL_W:0]     trial_sub;
  logic signed [SCALED_W:0] q_div;
  logic signed [SCALED_W:0] q_full;
  logic signed [SCALED_W:0] q_sat;
  logic [SLOT_W-1:0]  first_idx;

  function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] m);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

  assign cur_low   = low_r[cur_r];
  assign cur_high  = high_r[cur_r];
  assign cur_raw   = raw_r[cur_r];
  assign diff      = $signed({1'b0, cur_raw}) - $signed({1'b0, cur_low});
  assign span      = $signed({1'b0, cur_high}) - $signed({1'b0, cur_low});
  assign diff_mag  = diff[VAL_W] ? (VAL_W + 1)'(-diff) : diff;
  assign span_mag  = span[VAL_W] ? (VAL_W + 1)'(-span) : span;
  assign first_idx = first_set(mask_r);

  // one restoring step; remainder always stays below the divisor
  assign trial     = {rem_r, dq_r[DIV_W-1]};
  assign ge        = (trial >= {1'b0, smag_r});
  assign trial_sub = trial - {1'b0, smag_r};

  always_comb begin
    q_div = $signed({2'b00, dq_r});
    if (sign_r) begin
      q_div = -q_div;
    end
    q_full = zero_r ? $signed({diff_r[VAL_W], diff_r, {FRAC_W{1'b0}}}) : q_div;
    q_sat  = q_full;
    if (q_full > SAT_HI) begin
      q_sat = SAT_HI;
    end else if (q_full < SAT_LO) begin
      q_sat = SAT_LO;
    end
  end

  assign q_pop     = (state_r == S_IDLE) && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= '0;
      pending_r   <= 1'b0;
      mask_r      <= '0;
      n_emit_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        ctrl_r[s] <= '0;
        low_r[s]  <= '0;
        high_r[s] <= '0;
        raw_r[s]  <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            cmd_r  <= q_head;
            cur_r  <= q_head.slot;
            last_r <= 1'b1;
            case (q_head.op)
              OP_CC: begin
                // armed slots take the controller of this message first
                if (pending_r) begin
                  for (int s = 0; s < SLOTS; s++) begin
                    if (armed_r[s]) begin
                      ctrl_r[s] <= q_head.ctrl;
                    end
                  end
                end
                armed_r   <= '0;
                pending_r <= 1'b0;
                state_r   <= S_MATCH;
              end
              OP_ARM: begin
                armed_r[q_head.slot] <= 1'b1;
                pending_r            <= 1'b1;
                low_r[q_head.slot]   <= VAL_TOP;
                high_r[q_head.slot]  <= '0;
              end
              OP_SET_CTRL: begin
                ctrl_r[q_head.slot] <= q_head.data;
                state_r             <= S_LOAD;
              end
              OP_SET_LOW: begin
                low_r[q_head.slot] <= q_head.data;
                state_r            <= S_LOAD;
              end
              OP_SET_HIGH: begin
                high_r[q_head.slot] <= q_head.data;
                state_r             <= S_LOAD;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_MATCH: begin
          for (int s = 0; s < SLOTS; s++) begin
            mask_r[s] <= (ctrl_r[s] == cmd_r.ctrl);
          end
          n_emit_r <= '0;
          state_r  <= S_PICK;
        end
        S_PICK: begin
          if (mask_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            cur_r             <= first_idx;
            mask_r[first_idx] <= 1'b0;
            state_r           <= S_UPD;
          end
        end
        S_UPD: begin
          if (cmd_r.data < cur_low) begin
            low_r[cur_r] <= cmd_r.data;
          end
          if (cmd_r.data > cur_high) begin
            high_r[cur_r] <= cmd_r.data;
          end
          raw_r[cur_r] <= cmd_r.data;
          // past the report limit slots are updated but not reported
          if (n_emit_r == NEMIT_W'(MAX_RESULTS)) begin
            state_r <= S_PICK;
          end else begin
            last_r   <= (mask_r == '0) || (n_emit_r == NEMIT_W'(MAX_RESULTS - 1));
            n_emit_r <= n_emit_r + NEMIT_W'(1);
            state_r  <= S_LOAD;
          end
        end
        S_LOAD: begin
          diff_r  <= diff;
          sign_r  <= diff[VAL_W] ^ span[VAL_W];
          zero_r  <= (span == '0);
          smag_r  <= span_mag[VAL_W-1:0];
          dq_r    <= {diff_mag[VAL_W-1:0], {FRAC_W{1'b0}}};
          rem_r   <= '0;
          cnt_r   <= (span == '0) ? '0 : CNT_W'(DIV_STEPS);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r != '0) begin
            rem_r <= ge ? trial_sub[VAL_W-1:0] : trial[VAL_W-1:0];
            dq_r  <= {dq_r[DIV_W-2:0], ge};
            cnt_r <= cnt_r - CNT_W'(1);
          end else begin
            out_data_r.out_slot       <= cur_r;
            out_data_r.out_controller <= ctrl_r[cur_r];
            out_data_r.out_low        <= cur_low;
            out_data_r.out_high       <= cur_high;
            out_data_r.out_raw        <= cur_raw;
            out_data_r.scaled_value   <= q_sat[SCALED_W-1:0];
            out_data_r.last_result    <= last_r;
            out_valid_r               <= 1'b1;
            state_r                   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= (cmd_r.op == OP_CC) ? S_PICK : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/midi_cc_learn_autorange_mapper.sv */
// ----------------------------------------------------------------------------
// midi_cc_learn_autorange_mapper
// MIDI control-change learn and auto-range mapper with normalized output.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): MIDI messages and host commands
// (arm learn, set controller, set range low/high). Items go through a
// classifier into a four-entry command queue, so the input keeps taking
// items while earlier ones are still being worked on; in_stall rises only
// when the queue is full. Non-CC messages and bad commands are taken and
// dropped.
// Result channel (out_valid/out_stall/out_data): one result per reported
// slot, in ascending slot order, last_result set on the final one of an item.
// The back end runs one command at a time. A reported slot of a MIDI message
// goes through pick, range update, load, 23 serial divider steps, finish and
// output transfer; each message adds learn, match and a last pick. A host
// write goes through load, the divider steps, finish and output transfer;
// arm learn is done in idle. A flat range (high equal to low) skips the 23
// divider steps.
// A stalled result holds in the output register and the back end waits;
// the queue still fills meanwhile.
// Reset (rst_n low, synchronous) clears all slots to zero, disarms learn and
// empties the queue.
// ----------------------------------------------------------------------------
module midi_cc_learn_autorange_mapper (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mccl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mccl_pkg::out_item_t out_data
);
  import mccl_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    q_head;
  logic    q_push;
  logic    q_pop;

  mccl_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  mccl_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  mccl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // queue occupancy never passes its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= (QAW + 1)'(QDEPTH))
    else $error("command queue overflow");

  // back end only pops a command that is there
  assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty command queue");

  // a push while full would lose a command
  assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into full command queue");

  // occupancy moves by at most one per cycle; a push without a pop adds one
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> (q_stat.count == $past(q_stat.count) + (QAW + 1)'(1)))
    else $error("queue count did not follow a push");

endmodule
